[src/tkd_pkg.sv]
// Shared types, byte codes and key lookup functions for the terminal key decoder.
package tkd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 4;
    localparam int unsigned TEXT_W  = 32;
    localparam int unsigned LEN_W   = 3;
    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned M_DATA_W = 40;

    localparam logic [7:0] B_CR     = 8'h0D;
    localparam logic [7:0] B_LF     = 8'h0A;
    localparam logic [7:0] B_DEL    = 8'h7F;
    localparam logic [7:0] B_BS     = 8'h08;
    localparam logic [7:0] B_CTRL_C = 8'h03;
    localparam logic [7:0] B_CTRL_U = 8'h15;
    localparam logic [7:0] B_CTRL_D = 8'h04;
    localparam logic [7:0] B_ESC    = 8'h1B;
    localparam logic [7:0] B_LBRACK = 8'h5B;
    localparam logic [7:0] B_SS3    = 8'h4F;
    localparam logic [7:0] B_TILDE  = 8'h7E;
    localparam logic [7:0] B_FINAL_LO = 8'h40;
    localparam logic [7:0] B_FINAL_HI = 8'h7E;
    localparam logic [7:0] B_UP     = 8'h41;
    localparam logic [7:0] B_DOWN   = 8'h42;
    localparam logic [7:0] B_RIGHT  = 8'h43;
    localparam logic [7:0] B_LEFT   = 8'h44;
    localparam logic [7:0] B_HOME   = 8'h48;
    localparam logic [7:0] B_END    = 8'h46;
    localparam logic [7:0] B_DIG_1  = 8'h31;
    localparam logic [7:0] B_DIG_7  = 8'h37;
    localparam logic [7:0] B_DIG_4  = 8'h34;
    localparam logic [7:0] B_DIG_8  = 8'h38;

    localparam logic [7:0] MASK_2   = 8'hE0;
    localparam logic [7:0] LEAD_2   = 8'hC0;
    localparam logic [7:0] MASK_3   = 8'hF0;
    localparam logic [7:0] LEAD_3   = 8'hE0;
    localparam logic [7:0] MASK_4   = 8'hF8;
    localparam logic [7:0] LEAD_4   = 8'hF0;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ESC  = 3'd1,
        PH_CSI  = 3'd2,
        PH_SS3  = 3'd3,
        PH_UTF  = 3'd4
    } t_phase;

    typedef enum logic [3:0] {
        KEY_TEXT  = 4'd0,
        KEY_ENTER = 4'd1,
        KEY_BACK  = 4'd2,
        KEY_INTR  = 4'd3,
        KEY_CLEAR = 4'd4,
        KEY_EOF   = 4'd5,
        KEY_UP    = 4'd6,
        KEY_DOWN  = 4'd7,
        KEY_RIGHT = 4'd8,
        KEY_LEFT  = 4'd9,
        KEY_HOME  = 4'd10,
        KEY_END   = 4'd11
    } t_key_kind;

    typedef struct packed {
        logic      hit;
        t_key_kind kind;
    } t_key_hit;

    typedef struct packed {
        logic        valid;
        t_key_kind   kind;
        logic [31:0] bytes;
        logic [2:0]  len;
    } t_key_result;

    function automatic t_key_hit ctrl_key(input logic [7:0] b);
        t_key_hit r;
        r.hit  = 1'b1;
        r.kind = KEY_TEXT;
        case (b)
            B_CR, B_LF:  r.kind = KEY_ENTER;
            B_DEL, B_BS: r.kind = KEY_BACK;
            B_CTRL_C:    r.kind = KEY_INTR;
            B_CTRL_U:    r.kind = KEY_CLEAR;
            B_CTRL_D:    r.kind = KEY_EOF;
            default:     r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_key_hit final_key(input logic [7:0] b);
        t_key_hit r;
        r.hit  = 1'b1;
        r.kind = KEY_TEXT;
        case (b)
            B_UP:    r.kind = KEY_UP;
            B_DOWN:  r.kind = KEY_DOWN;
            B_RIGHT: r.kind = KEY_RIGHT;
            B_LEFT:  r.kind = KEY_LEFT;
            B_HOME:  r.kind = KEY_HOME;
            B_END:   r.kind = KEY_END;
            default: r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    // Length of a UTF-8 character from its lead byte; invalid leads count as one.
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] n;
        if (!b[7]) begin
            n = 3'd1;
        end else if ((b & MASK_2) == LEAD_2) begin
            n = 3'd2;
        end else if ((b & MASK_3) == LEAD_3) begin
            n = 3'd3;
        end else if ((b & MASK_4) == LEAD_4) begin
            n = 3'd4;
        end else begin
            n = 3'd1;
        end
        return n;
    endfunction

endpackage

[src/tkd_in_stage.sv]
// Input register holding one accepted byte until the parser takes it.
module tkd_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

[src/tkd_parser.sv]
// Parse state machine: turns each byte into at most one key result.
module tkd_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    output tkd_pkg::t_key_result o_res
);

    tkd_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_char_bytes, n_char_bytes;
    logic [2:0]  r_expected, n_expected;
    logic [2:0]  r_collected, n_collected;
    logic [1:0]  r_csi_count, n_csi_count;
    logic [7:0]  r_csi_first, n_csi_first;

    tkd_pkg::t_key_hit fin_hit;
    tkd_pkg::t_key_hit ctl_hit;
    logic [2:0]  lead_n;
    logic        is_final;
    logic [31:0] utf_bytes;
    logic [2:0]  utf_count;

    assign fin_hit   = tkd_pkg::final_key(i_byte);
    assign ctl_hit   = tkd_pkg::ctrl_key(i_byte);
    assign lead_n    = tkd_pkg::lead_len(i_byte);
    assign is_final  = (i_byte >= tkd_pkg::B_FINAL_LO) && (i_byte <= tkd_pkg::B_FINAL_HI);
    assign utf_count = r_collected + 3'd1;

    // Place the byte at the slot given by the number already collected.
    always_comb begin
        utf_bytes = r_char_bytes;
        case (r_collected[1:0])
            2'd0:    utf_bytes[7:0]   = r_char_bytes[7:0]   | i_byte;
            2'd1:    utf_bytes[15:8]  = r_char_bytes[15:8]  | i_byte;
            2'd2:    utf_bytes[23:16] = r_char_bytes[23:16] | i_byte;
            default: utf_bytes[31:24] = r_char_bytes[31:24] | i_byte;
        endcase
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            tkd_pkg::PH_ESC: begin
                if (i_byte == tkd_pkg::B_LBRACK) begin
                    n_phase = tkd_pkg::PH_CSI;
                end else if (i_byte == tkd_pkg::B_SS3) begin
                    n_phase = tkd_pkg::PH_SS3;
                end else begin
                    n_phase = tkd_pkg::PH_IDLE;
                end
            end
            tkd_pkg::PH_SS3: n_phase = tkd_pkg::PH_IDLE;
            tkd_pkg::PH_CSI: begin
                if (is_final) begin
                    n_phase = tkd_pkg::PH_IDLE;
                end
            end
            tkd_pkg::PH_UTF: begin
                if (utf_count >= r_expected) begin
                    n_phase = tkd_pkg::PH_IDLE;
                end
            end
            default: begin
                if (i_byte == tkd_pkg::B_ESC) begin
                    n_phase = tkd_pkg::PH_ESC;
                end else if (!ctl_hit.hit && lead_n != 3'd1) begin
                    n_phase = tkd_pkg::PH_UTF;
                end
            end
        endcase
    end

    // Result and next values of the data registers.
    always_comb begin
        o_res.valid  = 1'b0;
        o_res.kind   = tkd_pkg::KEY_TEXT;
        o_res.bytes  = 32'd0;
        o_res.len    = 3'd0;
        n_char_bytes = r_char_bytes;
        n_expected   = r_expected;
        n_collected  = r_collected;
        n_csi_count  = r_csi_count;
        n_csi_first  = r_csi_first;
        case (r_phase)
            tkd_pkg::PH_ESC: begin
                if (i_byte == tkd_pkg::B_LBRACK) begin
                    n_csi_count = 2'd0;
                    n_csi_first = 8'd0;
                end
            end
            tkd_pkg::PH_SS3: begin
                o_res.valid = fin_hit.hit;
                o_res.kind  = fin_hit.kind;
            end
            tkd_pkg::PH_CSI: begin
                if (is_final) begin
                    if (r_csi_count == 2'd0) begin
                        o_res.valid = fin_hit.hit;
                        o_res.kind  = fin_hit.kind;
                    end else if (r_csi_count == 2'd1 && i_byte == tkd_pkg::B_TILDE) begin
                        if (r_csi_first == tkd_pkg::B_DIG_1 || r_csi_first == tkd_pkg::B_DIG_7) begin
                            o_res.valid = 1'b1;
                            o_res.kind  = tkd_pkg::KEY_HOME;
                        end else if (r_csi_first == tkd_pkg::B_DIG_4 ||
                                     r_csi_first == tkd_pkg::B_DIG_8) begin
                            o_res.valid = 1'b1;
                            o_res.kind  = tkd_pkg::KEY_END;
                        end
                    end
                end else begin
                    if (r_csi_count == 2'd0) begin
                        n_csi_first = i_byte;
                    end
                    // Saturate at two: longer parameter runs never map.
                    if (r_csi_count != 2'd2) begin
                        n_csi_count = r_csi_count + 2'd1;
                    end
                end
            end
            tkd_pkg::PH_UTF: begin
                n_char_bytes = utf_bytes;
                n_collected  = utf_count;
                if (utf_count >= r_expected) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = tkd_pkg::KEY_TEXT;
                    o_res.bytes = utf_bytes;
                    o_res.len   = r_expected;
                end
            end
            default: begin
                if (i_byte != tkd_pkg::B_ESC) begin
                    if (ctl_hit.hit) begin
                        o_res.valid = 1'b1;
                        o_res.kind  = ctl_hit.kind;
                    end else if (lead_n == 3'd1) begin
                        o_res.valid = 1'b1;
                        o_res.kind  = tkd_pkg::KEY_TEXT;
                        o_res.bytes = {24'd0, i_byte};
                        o_res.len   = 3'd1;
                    end else begin
                        n_char_bytes = {24'd0, i_byte};
                        n_expected   = lead_n;
                        n_collected  = 3'd1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= tkd_pkg::PH_IDLE;
            r_char_bytes <= 32'd0;
            r_expected   <= 3'd0;
            r_collected  <= 3'd0;
            r_csi_count  <= 2'd0;
            r_csi_first  <= 8'd0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_char_bytes <= n_char_bytes;
            r_expected   <= n_expected;
            r_collected  <= n_collected;
            r_csi_count  <= n_csi_count;
            r_csi_first  <= n_csi_first;
        end
    end

    a_utf_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == tkd_pkg::PH_UTF |-> (r_collected != 3'd0) && (r_collected < r_expected)
                                       && (r_expected <= 3'd4))
        else $error("utf collection count out of range");

    a_non_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.kind != tkd_pkg::KEY_TEXT |-> o_res.len == 3'd0
                                                          && o_res.bytes == 32'd0)
        else $error("non-text key carries text");

    a_text_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.kind == tkd_pkg::KEY_TEXT |-> o_res.len != 3'd0
                                                          && o_res.len <= 3'd4)
        else $error("text key length out of range");

endmodule

[src/tkd_out_stage.sv]
// Result register: holds one key until the downstream side takes it.
module tkd_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  tkd_pkg::t_key_result i_res,
    output logic                 o_space,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [39:0]          o_data
);

    logic        r_valid;
    logic [3:0]  r_kind;
    logic [31:0] r_bytes;
    logic [2:0]  r_len;

    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = {1'b0, r_len, r_bytes, r_kind};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load && i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_load && i_res.valid) begin
            r_kind  <= 4'(i_res.kind);
            r_bytes <= i_res.bytes;
            r_len   <= i_res.len;
        end
    end

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_kind <= 4'(tkd_pkg::KEY_END))
        else $error("result kind out of range");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_bytes) && $stable(r_kind))
        else $error("stalled result changed");

    a_load_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load && i_res.valid && !o_space |-> 1'b0)
        else $error("result lost: loaded while full");

endmodule

[src/terminal_key_decoder.sv]
// Terminal key decoder: raw terminal bytes in, key events out.
// Path: the completing byte is held in the input register, parsed, and its key loaded into the result register.
// Throughput: one byte per cycle while the result register has space; bytes that finish no key produce no result.
// The figure is set by the single parse step between input and result register.
// Reset (i_rst_n low, synchronous) empties both registers and returns to idle.
module terminal_key_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [3:0] key_kind, [35:4] text_bytes, [38:36] text_length
);

    logic                 in_valid;
    logic [7:0]           in_byte;
    logic                 out_space;
    logic                 step;
    tkd_pkg::t_key_result res;

    // Advance a request only when the result register can take its key.
    assign step = in_valid && out_space;

    tkd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_byte  (s_tdata),
        .i_take  (step),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    tkd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (in_byte),
        .o_res   (res)
    );

    tkd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step),
        .i_res   (res),
        .o_space (out_space),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_data  (m_tdata)
    );

endmodule

[test/terminal_key_decoder_tb.sv]
// Testbench for the terminal key decoder: byte stream in, key events checked against a predictor.
module terminal_key_decoder_tb;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned PHASE_BYTES = 100;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct {
        tkd_pkg::t_key_kind kind;
        logic [31:0]        bytes;
        logic [2:0]         len;
    } t_key_event;

    class key_scoreboard;
        tkd_pkg::t_phase phase;
        logic [31:0] utf_bytes;
        logic [2:0]  utf_len;
        logic [2:0]  utf_got;
        logic [1:0]  csi_count;
        logic [7:0]  csi_first;
        t_key_event  pending_keys[$];
        int unsigned n_bad;
        int unsigned n_keys;
        bit [11:0]   kinds_seen;

        function new();
            phase      = tkd_pkg::PH_IDLE;
            utf_bytes  = '0;
            utf_len    = '0;
            utf_got    = '0;
            csi_count  = '0;
            csi_first  = '0;
            n_bad      = 0;
            n_keys     = 0;
            kinds_seen = '0;
        endfunction

        function bit final_kind(input logic [7:0] b, output tkd_pkg::t_key_kind k);
            k = tkd_pkg::KEY_TEXT;
            case (b)
                tkd_pkg::B_UP:    k = tkd_pkg::KEY_UP;
                tkd_pkg::B_DOWN:  k = tkd_pkg::KEY_DOWN;
                tkd_pkg::B_RIGHT: k = tkd_pkg::KEY_RIGHT;
                tkd_pkg::B_LEFT:  k = tkd_pkg::KEY_LEFT;
                tkd_pkg::B_HOME:  k = tkd_pkg::KEY_HOME;
                tkd_pkg::B_END:   k = tkd_pkg::KEY_END;
                default:          return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function bit ctrl_kind(input logic [7:0] b, output tkd_pkg::t_key_kind k);
            k = tkd_pkg::KEY_TEXT;
            case (b)
                tkd_pkg::B_CR, tkd_pkg::B_LF:  k = tkd_pkg::KEY_ENTER;
                tkd_pkg::B_DEL, tkd_pkg::B_BS: k = tkd_pkg::KEY_BACK;
                tkd_pkg::B_CTRL_C:             k = tkd_pkg::KEY_INTR;
                tkd_pkg::B_CTRL_U:             k = tkd_pkg::KEY_CLEAR;
                tkd_pkg::B_CTRL_D:             k = tkd_pkg::KEY_EOF;
                default:                       return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function logic [2:0] char_len(input logic [7:0] b);
            casez (b)
                8'b0???????: return 3'd1;
                8'b110?????: return 3'd2;
                8'b1110????: return 3'd3;
                8'b11110???: return 3'd4;
                default:     return 3'd1;
            endcase
        endfunction

        // Advance the parse state by one byte; returns 1 when a key comes out.
        function bit decode_byte(input logic [7:0] b, output t_key_event ev);
            tkd_pkg::t_key_kind k;
            bit                 hit;
            logic [2:0]         n;
            ev  = '{tkd_pkg::KEY_TEXT, 32'h0, 3'd0};
            hit = 1'b0;
            case (phase)
                tkd_pkg::PH_ESC: begin
                    if (b == tkd_pkg::B_LBRACK) begin
                        phase     = tkd_pkg::PH_CSI;
                        csi_count = '0;
                        csi_first = '0;
                    end else if (b == tkd_pkg::B_SS3) begin
                        phase = tkd_pkg::PH_SS3;
                    end else begin
                        phase = tkd_pkg::PH_IDLE;
                    end
                end
                tkd_pkg::PH_SS3: begin
                    phase   = tkd_pkg::PH_IDLE;
                    hit     = final_kind(b, k);
                    ev.kind = k;
                end
                tkd_pkg::PH_CSI: begin
                    if (b >= tkd_pkg::B_FINAL_LO && b <= tkd_pkg::B_FINAL_HI) begin
                        phase = tkd_pkg::PH_IDLE;
                        if (csi_count == 2'd0) begin
                            hit     = final_kind(b, k);
                            ev.kind = k;
                        end else if (csi_count == 2'd1 && b == tkd_pkg::B_TILDE) begin
                            if (csi_first == tkd_pkg::B_DIG_1 ||
                                csi_first == tkd_pkg::B_DIG_7) begin
                                hit     = 1'b1;
                                ev.kind = tkd_pkg::KEY_HOME;
                            end else if (csi_first == tkd_pkg::B_DIG_4 ||
                                         csi_first == tkd_pkg::B_DIG_8) begin
                                hit     = 1'b1;
                                ev.kind = tkd_pkg::KEY_END;
                            end
                        end
                    end else begin
                        if (csi_count == 2'd0) csi_first = b;
                        if (csi_count < 2'd2) csi_count++;
                    end
                end
                tkd_pkg::PH_UTF: begin
                    // continuation bytes are taken whatever they hold
                    if (utf_got < 3'd4) utf_bytes = utf_bytes | ({24'h0, b} << (8 * utf_got));
                    utf_got++;
                    if (utf_got >= utf_len) begin
                        phase    = tkd_pkg::PH_IDLE;
                        hit      = 1'b1;
                        ev.bytes = utf_bytes;
                        ev.len   = utf_len;
                    end
                end
                default: begin
                    if (b == tkd_pkg::B_ESC) begin
                        phase = tkd_pkg::PH_ESC;
                    end else if (ctrl_kind(b, k)) begin
                        hit     = 1'b1;
                        ev.kind = k;
                    end else begin
                        n = char_len(b);
                        if (n == 3'd1) begin
                            hit      = 1'b1;
                            ev.bytes = {24'h0, b};
                            ev.len   = 3'd1;
                        end else begin
                            utf_bytes = {24'h0, b};
                            utf_len   = n;
                            utf_got   = 3'd1;
                            phase     = tkd_pkg::PH_UTF;
                        end
                    end
                end
            endcase
            return hit;
        endfunction

        function void note_byte(input logic [7:0] b);
            t_key_event ev;
            if (decode_byte(b, ev)) pending_keys.insert(pending_keys.size(), ev);
        endfunction

        function void flag(input string msg);
            n_bad++;
            if (n_bad <= MAX_REPORTS) $display("ERROR: %s", msg);
        endfunction

        function void check_key(input logic [39:0] d);
            t_key_event  want;
            logic [3:0]  got_kind;
            logic [31:0] got_bytes;
            logic [2:0]  got_len;
            got_kind  = d[3:0];
            got_bytes = d[35:4];
            got_len   = d[38:36];
            n_keys++;
            if (got_kind < 4'd12) kinds_seen[got_kind] = 1'b1;
            if (pending_keys.size() == 0) begin
                flag($sformatf("key %0d not expected: kind %0d bytes %h len %0d",
                               n_keys, got_kind, got_bytes, got_len));
                return;
            end
            want = pending_keys.pop_front();
            if (got_kind !== want.kind || got_bytes !== want.bytes || got_len !== want.len)
                flag($sformatf({"key %0d: expected kind %0d bytes %h len %0d, ",
                                "got kind %0d bytes %h len %0d"},
                               n_keys, want.kind, want.bytes, want.len,
                               got_kind, got_bytes, got_len));
        endfunction
    endclass

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;  // [7:0] in_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // [3:0] key_kind, [35:4] text_bytes, [38:36] text_length

    key_scoreboard sb;
    int unsigned   bytes_taken = 0;
    int unsigned   quiet = 0;
    int unsigned   gap_pct = 0;
    int unsigned   stall_pct = 0;
    logic [7:0]    byte_plan[$];

    terminal_key_decoder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Sample both sides and run the watchdog on quiet cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                sb.note_byte(s_tdata);
                bytes_taken <= bytes_taken + 1;
            end
            if (m_tvalid && m_tready) sb.check_key(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet <= 0;
            end else if (quiet >= QUIET_LIMIT) begin
                $display("ERROR: no request moved for %0d cycles", QUIET_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the byte is taken.
    task automatic send_byte(input logic [7:0] b);
        int unsigned start;
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        start = bytes_taken;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(negedge i_clk); while (bytes_taken == start);
    endtask

    // Hold off the sender until every pending key has come out.
    task automatic drain_keys();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (sb.pending_keys.size() != 0);
    endtask

    // Append one byte to the plan.
    function automatic void plan_add(input logic [7:0] b);
        byte_plan.insert(byte_plan.size(), b);
    endfunction

    function automatic logic [7:0] pick_ctrl();
        case ($urandom_range(6))
            0:       return tkd_pkg::B_CR;
            1:       return tkd_pkg::B_LF;
            2:       return tkd_pkg::B_DEL;
            3:       return tkd_pkg::B_BS;
            4:       return tkd_pkg::B_CTRL_C;
            5:       return tkd_pkg::B_CTRL_U;
            default: return tkd_pkg::B_CTRL_D;
        endcase
    endfunction

    function automatic logic [7:0] pick_final();
        case ($urandom_range(6))
            0:       return tkd_pkg::B_UP;
            1:       return tkd_pkg::B_DOWN;
            2:       return tkd_pkg::B_RIGHT;
            3:       return tkd_pkg::B_LEFT;
            4:       return tkd_pkg::B_HOME;
            5:       return tkd_pkg::B_END;
            default: return 8'($urandom_range(tkd_pkg::B_FINAL_HI, tkd_pkg::B_FINAL_LO));
        endcase
    endfunction

    function automatic logic [7:0] pick_digit();
        case ($urandom_range(4))
            0:       return tkd_pkg::B_DIG_1;
            1:       return tkd_pkg::B_DIG_7;
            2:       return tkd_pkg::B_DIG_4;
            3:       return tkd_pkg::B_DIG_8;
            default: return 8'($urandom_range(8'h39, 8'h30));
        endcase
    endfunction

    // Mostly unchecked continuations are well formed; now and then any byte.
    function automatic logic [7:0] pick_cont();
        if ($urandom_range(7) == 0) return 8'($urandom_range(255));
        return 8'h80 | 8'($urandom_range(63));
    endfunction

    task automatic plan_sequence();
        logic [7:0] b;
        int unsigned n;
        case ($urandom_range(11))
            0: plan_add(pick_ctrl());
            1: plan_add(8'($urandom_range(8'h7E, 8'h20)));
            2: begin
                plan_add(8'hC0 | 8'($urandom_range(31)));
                plan_add(pick_cont());
            end
            3: begin
                plan_add(8'hE0 | 8'($urandom_range(15)));
                repeat (2) plan_add(pick_cont());
            end
            4: begin
                plan_add(8'hF0 | 8'($urandom_range(7)));
                repeat (3) plan_add(pick_cont());
            end
            5: begin
                if ($urandom_range(1)) plan_add(8'($urandom_range(8'hBF, 8'h80)));
                else plan_add(8'($urandom_range(8'hFF, 8'hF8)));
            end
            6: begin
                plan_add(tkd_pkg::B_ESC);
                plan_add(tkd_pkg::B_SS3);
                if ($urandom_range(3) == 0) plan_add(8'($urandom_range(255)));
                else plan_add(pick_final());
            end
            7: begin
                plan_add(tkd_pkg::B_ESC);
                plan_add(tkd_pkg::B_LBRACK);
                plan_add(pick_final());
            end
            8: begin
                plan_add(tkd_pkg::B_ESC);
                plan_add(tkd_pkg::B_LBRACK);
                plan_add(pick_digit());
                if ($urandom_range(3) == 0) plan_add(pick_final());
                else plan_add(tkd_pkg::B_TILDE);
            end
            9: begin
                // parameter run too long to map
                plan_add(tkd_pkg::B_ESC);
                plan_add(tkd_pkg::B_LBRACK);
                n = $urandom_range(4, 2);
                repeat (n) plan_add(8'($urandom_range(8'h3F, 8'h20)));
                if ($urandom_range(1)) plan_add(tkd_pkg::B_TILDE);
                else plan_add(pick_final());
            end
            10: begin
                plan_add(tkd_pkg::B_ESC);
                do b = 8'($urandom_range(255));
                while (b == tkd_pkg::B_LBRACK || b == tkd_pkg::B_SS3);
                if ($urandom_range(5) == 0) b = tkd_pkg::B_ESC;
                plan_add(b);
            end
            default: begin
                n = $urandom_range(3, 1);
                repeat (n) plan_add(8'($urandom_range(255)));
            end
        endcase
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // control keys, stray bytes, text of lengths one, two and four, escape and CSI forms
        byte_plan = '{tkd_pkg::B_CR, tkd_pkg::B_DEL, tkd_pkg::B_CTRL_C, tkd_pkg::B_CTRL_U,
                      tkd_pkg::B_CTRL_D, 8'h00, 8'hFF, 8'h80,
                      8'hC3, 8'hA9, 8'hF0, 8'h9F, 8'h98, 8'h80,
                      tkd_pkg::B_ESC, tkd_pkg::B_SS3, tkd_pkg::B_UP,
                      tkd_pkg::B_ESC, tkd_pkg::B_LBRACK, tkd_pkg::B_DIG_4, tkd_pkg::B_TILDE,
                      tkd_pkg::B_ESC, tkd_pkg::B_LBRACK, tkd_pkg::B_DIG_1, 8'h32,
                      tkd_pkg::B_TILDE,
                      tkd_pkg::B_ESC, tkd_pkg::B_ESC,
                      8'hC2, tkd_pkg::B_ESC};
        foreach (byte_plan[i]) send_byte(byte_plan[i]);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 80; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 80; end
                default: begin gap_pct = 21; stall_pct = 21; end
            endcase
            byte_plan.delete();
            while (byte_plan.size() < PHASE_BYTES) plan_sequence();
            foreach (byte_plan[i]) send_byte(byte_plan[i]);
            drain_keys();
        end

        s_tvalid  <= 1'b0;
        stall_pct = 0;
        while (sb.pending_keys.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.pending_keys.size() != 0)
            sb.flag($sformatf("%0d keys never came out", sb.pending_keys.size()));

        $display("Sent %0d bytes over four pacing phases; checked %0d keys, %0d of 12 kinds seen.",
                 bytes_taken, sb.n_keys, $countones(sb.kinds_seen));
        $display("Mismatches: %0d", sb.n_bad);
        if (sb.n_bad == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[files.f]
src/tkd_pkg.sv
src/tkd_in_stage.sv
src/tkd_parser.sv
src/tkd_out_stage.sv
src/terminal_key_decoder.sv
test/terminal_key_decoder_tb.sv
